/* src/assert_macros.svh */
// Assertion macros for the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define PDHH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted
`define PDHH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* src/pdhh_pkg.sv */
// Shared widths, constants and register codes of the drive heading hold controller
`timescale 1ns / 1ps
`default_nettype none

package pdhh_pkg;

	// Fixed field widths
	localparam int TARGET_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int HEADING_W  = 21;
	localparam int TIME_W     = 16;
	localparam int DRIVE_W    = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 3;

	// Heading error is one bit wider than the heading
	localparam int HERR_W = HEADING_W + 1;

	// Drive limits and settle windows
	localparam int DRIVE_LIMIT  = 127;
	localparam int POS_SETTLE   = 5;
	localparam int HEAD_SETTLE  = 75;
	localparam int IZONE        = 10;
	localparam int IZONE_W      = 5;

	// Q8.8 gain products drop eight fraction bits
	localparam int FRAC_BITS = 8;
	localparam int FRAC_MASK = 255;

	// Turn = herr * 7 / 200: /8 by shift, then /25 by reciprocal 2^26/25 rounded up
	localparam int TURN_RECIP_W = 22;
	localparam logic [TURN_RECIP_W-1:0] TURN_RECIP = 22'd2684355;
	localparam int TURN_SHIFT = 26;
	localparam int TURN_PROD_W = HERR_W + TURN_RECIP_W;
	localparam int TURN_W = 18;

	// Configuration register codes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_TICKS   = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_HEADING_TARGET = 3'd4,
		REG_TIMEOUT_MS     = 3'd5
	} cfg_reg_t;

endpackage

`default_nettype wire

/* src/pid_drive_heading_hold_core.sv */
// Drive heading hold controller: sample in, left and right drive commands out.
// Takes one sensor word per clock while the output is not stalled and returns
// one drive word per sample, through an input register, a product register
// after the errors, loop state update and the gain and turn multiplies, and the
// output register after the sum, scaling and side mixing. The integral, the
// previous error and the done latch update in the first stage, so samples
// follow each other without gaps. A stalled output holds the two registers in
// front of it; the input side stops only once they are full.
// Configuration writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module pid_drive_heading_hold_core #(
	parameter int POSITION_WIDTH = 24,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [POSITION_WIDTH-1:0]        position,
	input  logic signed [pdhh_pkg::HEADING_W-1:0]   heading,
	input  logic        [pdhh_pkg::TIME_W-1:0]      elapsed_ms,
	input  logic                                    first_sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [pdhh_pkg::DRIVE_W-1:0]     left_drive,
	output logic signed [pdhh_pkg::DRIVE_W-1:0]     right_drive,
	output logic                                    finished,
	input  logic                                    cfg_write_en,
	input  logic        [pdhh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [pdhh_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pdhh_pkg::*;

	localparam int ERR_W = ((POSITION_WIDTH > TARGET_W) ? POSITION_WIDTH : TARGET_W) + 1;
	localparam int PP_W  = ERR_W + GAIN_W + 1;
	localparam int IP_W  = INTEGRAL_WIDTH + GAIN_W + 1;
	localparam int DP_W  = ERR_W + GAIN_W + 2;

	// Configuration
	logic signed [TARGET_W-1:0]  target_ticks_q;
	logic        [GAIN_W-1:0]    gain_p_q;
	logic        [GAIN_W-1:0]    gain_i_q;
	logic        [GAIN_W-1:0]    gain_d_q;
	logic signed [HEADING_W-1:0] heading_target_q;
	logic        [TIME_W-1:0]    timeout_ms_q;

	// Input stage
	logic                         valid_s1;
	logic signed [POSITION_WIDTH-1:0] position_s1;
	logic signed [HEADING_W-1:0]  heading_s1;
	logic        [TIME_W-1:0]     elapsed_ms_s1;
	logic                         first_sample_s1;

	// Product stage
	logic                         valid_s2;
	logic signed [PP_W-1:0]       p_prod_s2;
	logic signed [IP_W-1:0]       i_prod_s2;
	logic signed [DP_W-1:0]       d_prod_s2;
	logic signed [TURN_W-1:0]     turn_s2;
	logic                         finished_s2;

	// Output stage
	logic                         out_valid_q;
	logic signed [DRIVE_W-1:0]    left_drive_q;
	logic signed [DRIVE_W-1:0]    right_drive_q;
	logic                         finished_q;

	logic                         adv_out;
	logic                         adv_s2;
	logic                         adv_s1;
	logic                         step;
	logic signed [PP_W-1:0]       p_prod;
	logic signed [IP_W-1:0]       i_prod;
	logic signed [DP_W-1:0]       d_prod;
	logic signed [TURN_W-1:0]     turn;
	logic                         law_finished;
	logic signed [DRIVE_W-1:0]    mix_left;
	logic signed [DRIVE_W-1:0]    mix_right;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_ticks_q   <= '0;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			heading_target_q <= '0;
			timeout_ms_q     <= '0;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_TICKS:   target_ticks_q   <= cfg_data[TARGET_W-1:0];
				REG_GAIN_P:         gain_p_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         gain_i_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         gain_d_q         <= cfg_data[GAIN_W-1:0];
				REG_HEADING_TARGET: heading_target_q <= cfg_data[HEADING_W-1:0];
				REG_TIMEOUT_MS:     timeout_ms_q     <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage advances when the one after it has room
	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s2   = !valid_s2 || adv_out;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign step     = valid_s1 && adv_s2;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			position_s1     <= position;
			heading_s1      <= heading;
			elapsed_ms_s1   <= elapsed_ms;
			first_sample_s1 <= first_sample;
		end
	end

	pdhh_law #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_law (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.target_ticks  (target_ticks_q),
		.gain_p        (gain_p_q),
		.gain_i        (gain_i_q),
		.gain_d        (gain_d_q),
		.heading_target(heading_target_q),
		.timeout_ms    (timeout_ms_q),
		.position      (position_s1),
		.heading       (heading_s1),
		.elapsed_ms    (elapsed_ms_s1),
		.first_sample  (first_sample_s1),
		.p_prod        (p_prod),
		.i_prod        (i_prod),
		.d_prod        (d_prod),
		.turn          (turn),
		.finished      (law_finished)
	);

	// Register the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			p_prod_s2   <= p_prod;
			i_prod_s2   <= i_prod;
			d_prod_s2   <= d_prod;
			turn_s2     <= turn;
			finished_s2 <= law_finished;
		end
	end

	pdhh_mix #(
		.ERR_W         (ERR_W),
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_mix (
		.p_prod     (p_prod_s2),
		.i_prod     (i_prod_s2),
		.d_prod     (d_prod_s2),
		.turn       (turn_s2),
		.finished   (finished_s2),
		.left_drive (mix_left),
		.right_drive(mix_right)
	);

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			left_drive_q  <= mix_left;
			right_drive_q <= mix_right;
			finished_q    <= finished_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_drive_q;
	assign right_drive = right_drive_q;
	assign finished    = finished_q;

endmodule

`default_nettype wire

/* src/pdhh_law.sv */
// Stage one: errors, settle test, loop state and the gain and turn products
`timescale 1ns / 1ps
`default_nettype none

module pdhh_law #(
	parameter int POSITION_WIDTH = 24,
	parameter int INTEGRAL_WIDTH = 32,
	localparam int ERR_W = ((POSITION_WIDTH > pdhh_pkg::TARGET_W) ?
		POSITION_WIDTH : pdhh_pkg::TARGET_W) + 1,
	localparam int PP_W = ERR_W + pdhh_pkg::GAIN_W + 1,
	localparam int IP_W = INTEGRAL_WIDTH + pdhh_pkg::GAIN_W + 1,
	localparam int DP_W = ERR_W + pdhh_pkg::GAIN_W + 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  logic signed [pdhh_pkg::TARGET_W-1:0]  target_ticks,
	input  logic        [pdhh_pkg::GAIN_W-1:0]    gain_p,
	input  logic        [pdhh_pkg::GAIN_W-1:0]    gain_i,
	input  logic        [pdhh_pkg::GAIN_W-1:0]    gain_d,
	input  logic signed [pdhh_pkg::HEADING_W-1:0] heading_target,
	input  logic        [pdhh_pkg::TIME_W-1:0]    timeout_ms,
	input  logic signed [POSITION_WIDTH-1:0]      position,
	input  logic signed [pdhh_pkg::HEADING_W-1:0] heading,
	input  logic        [pdhh_pkg::TIME_W-1:0]    elapsed_ms,
	input  logic                                  first_sample,
	output logic signed [PP_W-1:0]                p_prod,
	output logic signed [IP_W-1:0]                i_prod,
	output logic signed [DP_W-1:0]                d_prod,
	output logic signed [pdhh_pkg::TURN_W-1:0]    turn,
	output logic                                  finished
);
	import pdhh_pkg::*;

	logic signed [INTEGRAL_WIDTH-1:0] error_integral_q;
	logic signed [ERR_W-1:0]          previous_error_q;
	logic                             done_q;

	logic signed [ERR_W-1:0]          err;
	logic signed [HERR_W-1:0]         herr;
	logic signed [INTEGRAL_WIDTH-1:0] integral_cur;
	logic signed [ERR_W-1:0]          prev_cur;
	logic                             done_cur;
	logic                             settled;
	logic                             timed_out;
	logic                             done_next;
	logic signed [ERR_W:0]            deriv;
	logic                             in_zone;
	logic signed [IZONE_W-1:0]        err_small;
	logic signed [INTEGRAL_WIDTH:0]   isum;
	logic signed [INTEGRAL_WIDTH-1:0] integral_sat;
	logic signed [INTEGRAL_WIDTH-1:0] integral_new;
	logic        [HERR_W-1:0]         herr_mag;
	logic        [HERR_W+2:0]         herr_x7;
	logic        [HERR_W-1:0]         herr_div8;
	logic        [TURN_PROD_W-1:0]    turn_prod;
	logic        [TURN_W-2:0]         turn_mag;

	// Distance and heading errors
	assign err  = ERR_W'(target_ticks) - ERR_W'(position);
	assign herr = HERR_W'(heading_target) - HERR_W'(heading);

	// A new move clears the integral and the latch and seeds the previous error
	assign integral_cur = first_sample ? '0 : error_integral_q;
	assign prev_cur     = first_sample ? err : previous_error_q;
	assign done_cur     = first_sample ? 1'b0 : done_q;

	// Stop when both errors sit in their windows or time has run out
	assign settled   = (err >= -POS_SETTLE) && (err <= POS_SETTLE) &&
		(herr >= -HEAD_SETTLE) && (herr <= HEAD_SETTLE);
	assign timed_out = elapsed_ms >= timeout_ms;
	assign done_next = done_cur || settled || timed_out;

	// Derivative against the previous error
	assign deriv = (ERR_W+1)'(err) - (ERR_W+1)'(prev_cur);

	// Integrate only inside the zone; there the error fits in a few bits
	assign in_zone   = (err > -IZONE) && (err < IZONE);
	assign err_small = err[IZONE_W-1:0];
	assign isum      = (INTEGRAL_WIDTH+1)'(integral_cur) + (INTEGRAL_WIDTH+1)'(err_small);

	// Saturate the integral to its signed range
	always_comb begin
		if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
			integral_sat = {isum[INTEGRAL_WIDTH], {(INTEGRAL_WIDTH-1){~isum[INTEGRAL_WIDTH]}}};
		end else begin
			integral_sat = isum[INTEGRAL_WIDTH-1:0];
		end
	end

	assign integral_new = in_zone ? integral_sat : integral_cur;

	// Hold the loop state; a stopped step keeps only the new-move clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_integral_q <= '0;
			previous_error_q <= '0;
			done_q           <= 1'b0;
		end else if (step) begin
			done_q <= done_next;
			if (done_next) begin
				error_integral_q <= integral_cur;
				previous_error_q <= prev_cur;
			end else begin
				error_integral_q <= integral_new;
				previous_error_q <= err;
			end
		end
	end

	// Gain products in Q8.8
	assign p_prod = PP_W'(err) * PP_W'($signed({1'b0, gain_p}));
	assign i_prod = IP_W'(integral_new) * IP_W'($signed({1'b0, gain_i}));
	assign d_prod = DP_W'(deriv) * DP_W'($signed({1'b0, gain_d}));

	// Turn on the magnitude, truncated toward zero, sign restored after
	assign herr_mag  = herr[HERR_W-1] ? HERR_W'(-herr) : HERR_W'(herr);
	assign herr_x7   = ((HERR_W+3)'(herr_mag) << 3) - (HERR_W+3)'(herr_mag);
	assign herr_div8 = herr_x7[HERR_W+2:3];
	assign turn_prod = TURN_PROD_W'(herr_div8) * TURN_PROD_W'(TURN_RECIP);
	assign turn_mag  = turn_prod[TURN_SHIFT +: TURN_W-1];
	assign turn      = herr[HERR_W-1] ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});

	assign finished = done_next;

endmodule

`default_nettype wire

/* src/pdhh_mix.sv */
// Stage two: sum the gain products, scale, clamp and mix in the turn
`timescale 1ns / 1ps
`default_nettype none

module pdhh_mix #(
	parameter int ERR_W = 25,
	parameter int INTEGRAL_WIDTH = 32,
	localparam int PP_W = ERR_W + pdhh_pkg::GAIN_W + 1,
	localparam int IP_W = INTEGRAL_WIDTH + pdhh_pkg::GAIN_W + 1,
	localparam int DP_W = ERR_W + pdhh_pkg::GAIN_W + 2
) (
	input  logic signed [PP_W-1:0]               p_prod,
	input  logic signed [IP_W-1:0]               i_prod,
	input  logic signed [DP_W-1:0]               d_prod,
	input  logic signed [pdhh_pkg::TURN_W-1:0]   turn,
	input  logic                                 finished,
	output logic signed [pdhh_pkg::DRIVE_W-1:0]  left_drive,
	output logic signed [pdhh_pkg::DRIVE_W-1:0]  right_drive
);
	import pdhh_pkg::*;

	localparam int MAX_W = (IP_W > DP_W) ? IP_W : DP_W;
	localparam int SUM_W = MAX_W + 2;

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   bias;
	logic signed [SUM_W-1:0]   scaled;
	logic signed [DRIVE_W-1:0] fwd;
	logic signed [TURN_W:0]    left_sum;
	logic signed [TURN_W:0]    right_sum;

	function automatic logic signed [DRIVE_W-1:0] clamp_drive(input logic signed [TURN_W:0] v);
		logic signed [DRIVE_W-1:0] r;
		if (v > DRIVE_LIMIT) begin
			r = DRIVE_W'(DRIVE_LIMIT);
		end else if (v < -DRIVE_LIMIT) begin
			r = DRIVE_W'(-DRIVE_LIMIT);
		end else begin
			r = v[DRIVE_W-1:0];
		end
		return r;
	endfunction

	// Sum the three terms
	assign sum = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);

	// Drop the fraction, truncating toward zero
	assign bias   = sum[SUM_W-1] ? SUM_W'(FRAC_MASK) : '0;
	assign scaled = (sum + bias) >>> FRAC_BITS;

	// Clamp the forward command
	always_comb begin
		if (scaled > DRIVE_LIMIT) begin
			fwd = DRIVE_W'(DRIVE_LIMIT);
		end else if (scaled < -DRIVE_LIMIT) begin
			fwd = DRIVE_W'(-DRIVE_LIMIT);
		end else begin
			fwd = scaled[DRIVE_W-1:0];
		end
	end

	// Mix forward and turn per side, then zero both once stopped
	assign left_sum  = (TURN_W+1)'(fwd) + (TURN_W+1)'(turn);
	assign right_sum = (TURN_W+1)'(fwd) - (TURN_W+1)'(turn);

	assign left_drive  = finished ? '0 : clamp_drive(left_sum);
	assign right_drive = finished ? '0 : clamp_drive(right_sum);

endmodule

`default_nettype wire

/* src/pdhh_checker.sv */
// Port-level checks on the result side of the heading hold controller
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdhh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pdhh_pkg::DRIVE_W-1:0] left_drive,
	input logic signed [pdhh_pkg::DRIVE_W-1:0] right_drive,
	input logic                                finished
);
	import pdhh_pkg::*;

	// A stopped move drives both sides to zero
	`PDHH_ASSERT_IMP(a_finished_zero, clk, arst_n, out_valid && finished, (left_drive == '0) && (right_drive == '0))

	// Drives never reach the most negative code
	`PDHH_ASSERT_IMP(a_drive_range, clk, arst_n, out_valid, (left_drive != DRIVE_W'(-DRIVE_LIMIT - 1)) && (right_drive != DRIVE_W'(-DRIVE_LIMIT - 1)))

	// A stalled result word holds
	`PDHH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(left_drive) && $stable(right_drive) && $stable(finished))

endmodule

bind pid_drive_heading_hold_core pdhh_checker u_pdhh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.left_drive (left_drive),
	.right_drive(right_drive),
	.finished   (finished)
);

`default_nettype wire

/* verif/tb_pid_drive_heading_hold_core.sv */
// Self-checking testbench for the drive heading hold controller core
`timescale 1ns / 1ps

module tb_pid_drive_heading_hold_core;
	import pdhh_pkg::*;

	localparam int POS_W = 24;
	localparam int INTEG_W = 32;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 145;

	localparam longint POS_MIN = -64'sd8388608;
	localparam longint POS_MAX = 64'sd8388607;
	localparam longint HEAD_MIN = -64'sd1048576;
	localparam longint HEAD_MAX = 64'sd1048575;
	localparam longint GAIN_MAX = 64'sd65535;
	localparam longint TIME_MAX = 64'sd65535;

	// Indexes past the last register: writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left;
		logic signed [DRIVE_W-1:0] right;
		logic                      fin;
	} drive_word_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [POS_W-1:0]           position;
	logic signed [HEADING_W-1:0]       heading;
	logic        [TIME_W-1:0]          elapsed_ms;
	logic                              first_sample;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [DRIVE_W-1:0]         left_drive;
	logic signed [DRIVE_W-1:0]         right_drive;
	logic                              finished;
	logic                              cfg_write_en;
	logic        [CFG_INDEX_W-1:0]     cfg_index;
	logic        [CFG_DATA_W-1:0]      cfg_data;

	// Shadow registers and loop state of the controller
	longint target_ticks = 0;
	longint gain_p = 0;
	longint gain_i = 0;
	longint gain_d = 0;
	longint heading_target = 0;
	longint timeout_ms = 0;
	longint error_integral = 0;
	longint last_error = 0;
	bit     move_done = 0;

	drive_word_t expected_drive[$];
	int samples_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 23;
	int recv_idle_pct = 55;

	pid_drive_heading_hold_core #(
		.POSITION_WIDTH(POS_W),
		.INTEGRAL_WIDTH(INTEG_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.position(position),
		.heading(heading),
		.elapsed_ms(elapsed_ms),
		.first_sample(first_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.finished(finished),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Mirror a register write into the shadow copy
	function automatic void store_setting(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TARGET_TICKS:   target_ticks = longint'($signed(data[TARGET_W-1:0]));
			REG_GAIN_P:         gain_p = longint'(data[GAIN_W-1:0]);
			REG_GAIN_I:         gain_i = longint'(data[GAIN_W-1:0]);
			REG_GAIN_D:         gain_d = longint'(data[GAIN_W-1:0]);
			REG_HEADING_TARGET: heading_target = longint'($signed(data[HEADING_W-1:0]));
			REG_TIMEOUT_MS:     timeout_ms = longint'(data[TIME_W-1:0]);
			default: ;
		endcase
	endfunction

	// Advance the loop state by one sample and return the drive word it yields
	function automatic drive_word_t predict_drive(logic signed [POS_W-1:0] pos,
			logic signed [HEADING_W-1:0] head, logic [TIME_W-1:0] ms, logic first);
		drive_word_t w;
		longint err, herr, deriv, sum, fwd, turn;
		longint imax, imin;
		imax = (64'sd1 <<< (INTEG_W - 1)) - 1;
		imin = -imax - 1;
		err = target_ticks - longint'(pos);
		herr = heading_target - longint'(head);
		if (first) begin
			error_integral = 0;
			last_error = err;
			move_done = 0;
		end
		if (!move_done) begin
			if ((magnitude(err) <= POS_SETTLE && magnitude(herr) <= HEAD_SETTLE)
					|| longint'(ms) >= timeout_ms)
				move_done = 1;
		end
		if (move_done) begin
			w.left = '0;
			w.right = '0;
			w.fin = 1'b1;
			return w;
		end
		deriv = err - last_error;
		last_error = err;
		if (magnitude(err) < IZONE)
			error_integral = clamp_to(error_integral + err, imin, imax);
		sum = err * gain_p + error_integral * gain_i + deriv * gain_d;
		fwd = clamp_to(sum / 256, -DRIVE_LIMIT, DRIVE_LIMIT);
		// 3.5 per degree on centidegrees, truncated toward zero
		turn = (herr * 7) / 200;
		w.left = DRIVE_W'(clamp_to(fwd + turn, -DRIVE_LIMIT, DRIVE_LIMIT));
		w.right = DRIVE_W'(clamp_to(fwd - turn, -DRIVE_LIMIT, DRIVE_LIMIT));
		w.fin = 1'b0;
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Track writes, predict each accepted sample, check each drive word
	always @(posedge clk) begin : monitor
		drive_word_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_write_en)
				store_setting(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				expected_drive.push_back(predict_drive(position, heading, elapsed_ms,
					first_sample));
				samples_taken++;
				quiet_cycles = 0;
			end
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				if (expected_drive.size() == 0) begin
					report_mismatch("drive word with nothing expected");
				end else begin
					want = expected_drive.pop_front();
					if (left_drive !== want.left)
						report_mismatch($sformatf("left_drive got %0d expected %0d",
							left_drive, want.left));
					if (right_drive !== want.right)
						report_mismatch($sformatf("right_drive got %0d expected %0d",
							right_drive, want.right));
					if (finished !== want.fin)
						report_mismatch($sformatf("finished got %0b expected %0b",
							finished, want.fin));
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_pid_drive_heading_hold_core: FAIL");
				$finish;
			end
		end
	end

	// Stall the output side at random
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Present one sample word and hold it until accepted
	task automatic send_sample(input longint pos, input longint head, input longint ms,
			input bit first);
		int target_count;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		position <= pos[POS_W-1:0];
		heading <= head[HEADING_W-1:0];
		elapsed_ms <= ms[TIME_W-1:0];
		first_sample <= first;
		target_count = samples_taken + 1;
		do
			@(negedge clk);
		while (samples_taken < target_count);
	endtask

	// Drop valid and wait until every drive word has come back
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	// No first mark after reset: derivative sees the whole error
	task automatic test_derivative_after_reset();
		write_reg(REG_TIMEOUT_MS, 1000);
		write_reg(REG_GAIN_D, 256);
		write_reg(REG_TARGET_TICKS, 100);
		send_sample(0, 0, 0, 0);
		send_sample(50, 0, 1, 0);
		settle_block();
	endtask

	// Zero timeout stops at once; elapsed at the timeout stops and latches
	task automatic test_timeout_stop();
		write_reg(REG_TIMEOUT_MS, 0);
		write_reg(REG_GAIN_P, 512);
		send_sample(-400, 300, 0, 1);
		settle_block();
		write_reg(REG_TIMEOUT_MS, 50);
		send_sample(-400, 300, 49, 1);
		send_sample(-300, 200, 50, 0);
		send_sample(-200, 100, 0, 0);
		send_sample(-200, 100, 0, 1);
		settle_block();
	endtask

	// Walk into the integral zone, settle, hold the latch, restart
	task automatic test_settle_and_latch();
		write_reg(REG_TARGET_TICKS, 1000);
		write_reg(REG_GAIN_P, 256);
		write_reg(REG_GAIN_I, 128);
		write_reg(REG_GAIN_D, 64);
		write_reg(REG_HEADING_TARGET, 0);
		write_reg(REG_TIMEOUT_MS, 65535);
		send_sample(900, 200, 0, 1);
		send_sample(990, 29, 10, 0);
		send_sample(992, -29, 20, 0);
		send_sample(994, 76, 30, 0);
		send_sample(995, 76, 40, 0);
		send_sample(995, 75, 50, 0);
		send_sample(2000, 0, 60, 0);
		send_sample(995, -75, 0, 1);
		send_sample(1006, 0, 0, 1);
		settle_block();
	endtask

	// Extremes of every field, gains at full scale and then P and I at zero, D at one
	task automatic test_field_extremes();
		write_reg(REG_GAIN_P, GAIN_MAX);
		write_reg(REG_GAIN_I, GAIN_MAX);
		write_reg(REG_GAIN_D, GAIN_MAX);
		write_reg(REG_TARGET_TICKS, POS_MAX);
		write_reg(REG_HEADING_TARGET, HEAD_MIN);
		write_reg(REG_TIMEOUT_MS, TIME_MAX);
		send_sample(POS_MIN, HEAD_MAX, 0, 1);
		send_sample(POS_MAX, HEAD_MIN, 1, 0);
		send_sample(POS_MIN, 0, TIME_MAX - 1, 0);
		send_sample(POS_MIN, 0, TIME_MAX, 0);
		settle_block();
		write_reg(REG_TARGET_TICKS, POS_MIN);
		write_reg(REG_HEADING_TARGET, HEAD_MAX);
		write_reg(REG_GAIN_P, 0);
		write_reg(REG_GAIN_I, 0);
		write_reg(REG_GAIN_D, 1);
		write_reg(SPARE_INDEX_LO, 64'hFFFFFF);
		write_reg(SPARE_INDEX_HI, 64'hFFFFFF);
		send_sample(POS_MAX, HEAD_MIN, 0, 1);
		send_sample(POS_MIN + 7, HEAD_MAX, 5, 0);
		settle_block();
	endtask

	// Pick a register value: mostly typical, sometimes an extreme or raw bits
	function automatic longint pick_value(bit extreme, longint lo, longint hi,
			int typical);
		int r;
		longint base;
		r = $urandom_range(7);
		if (extreme)
			return (r < 4) ? lo : hi;
		if (r == 0)
			return longint'($urandom);
		if (r == 1)
			return lo;
		if (r == 2)
			return hi;
		base = (lo < 0) ? -typical : 0;
		return base + longint'($urandom_range(typical - base));
	endfunction

	task automatic write_random_setting(input bit extreme);
		write_reg(REG_TARGET_TICKS, pick_value(extreme, POS_MIN, POS_MAX, 20000));
		write_reg(REG_GAIN_P, pick_value(extreme, 0, GAIN_MAX, 1024));
		write_reg(REG_GAIN_I, pick_value(extreme, 0, GAIN_MAX, 512));
		write_reg(REG_GAIN_D, pick_value(extreme, 0, GAIN_MAX, 1024));
		write_reg(REG_HEADING_TARGET, pick_value(extreme, HEAD_MIN, HEAD_MAX, 4000));
		write_reg(REG_TIMEOUT_MS, pick_value(extreme, 0, TIME_MAX, 3000));
	endtask

	// One move: errors shrink toward the settle window with some jitter
	task automatic run_move(input bit with_first, inout int sent);
		longint err, herr, ms;
		int steps, span;
		case ($urandom_range(3))
			0: span = 20;
			1: span = 500;
			2: span = 5000;
			default: span = 4000000;
		endcase
		err = longint'($urandom_range(2 * span)) - span;
		span = ($urandom_range(1)) ? 200 : 4000;
		herr = longint'($urandom_range(2 * span)) - span;
		ms = ($urandom_range(9) == 0) ? TIME_MAX - 40 : longint'($urandom_range(3));
		steps = $urandom_range(40, 3);
		for (int i = 0; i < steps; i++) begin
			send_sample(clamp_to(target_ticks - err, POS_MIN, POS_MAX),
				clamp_to(heading_target - herr, HEAD_MIN, HEAD_MAX), ms,
				(i == 0) && with_first);
			sent++;
			err = (err * longint'($urandom_range(95, 50))) / 100
				+ longint'($urandom_range(4)) - 2;
			herr = (herr * longint'($urandom_range(95, 40))) / 100
				+ longint'($urandom_range(10)) - 5;
			ms = clamp_to(ms + longint'($urandom_range(40)), 0, TIME_MAX);
		end
	endtask

	// Random moves over several settings under one idling pattern
	task automatic test_random_moves(input int sender_idle, input int receiver_idle);
		int sent;
		int r;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		for (int setting = 0; setting < 4; setting++) begin
			settle_block();
			write_random_setting(setting == 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 10) begin
					send_sample(longint'($urandom), longint'($urandom),
						longint'($urandom), $urandom_range(1));
					sent++;
				end else begin
					run_move(r >= 22, sent);
				end
			end
		end
		settle_block();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		position = '0;
		heading = '0;
		elapsed_ms = '0;
		first_sample = 1'b0;
		out_ready = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_derivative_after_reset();
		test_timeout_stop();
		test_settle_and_latch();
		test_field_extremes();
		test_random_moves(23, 55);
		test_random_moves(55, 23);
		test_random_moves(0, 0);

		settle_block();
		if (expected_drive.size() != 0)
			report_mismatch($sformatf("%0d drive words never arrived",
				expected_drive.size()));
		if (mismatches == 0)
			$display("tb_pid_drive_heading_hold_core: PASS");
		else
			$display("tb_pid_drive_heading_hold_core: FAIL");
		$finish;
	end

endmodule
